>>> hdl/accel_tilt_estimator_core_assert.svh
// Assertion macros for the tilt estimator core
`ifndef ACCEL_TILT_ESTIMATOR_CORE_ASSERT_SVH
`define ACCEL_TILT_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define ATE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tilt estimator assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ATE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tilt estimator assertion failed");

`endif

>>> hdl/ate_pkg.sv
// Types, constants and helpers for the accelerometer tilt estimator
`timescale 1ns / 1ps
`default_nettype none

package ate_pkg;

  localparam int unsigned AccelW    = 16;
  localparam int unsigned FiltW     = 24;
  localparam int unsigned UnitW     = 16;
  localparam int unsigned MulW      = 25;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned SqW       = 48;
  localparam int unsigned RootW     = 25;
  localparam int unsigned QuotW     = 15;
  localparam int unsigned CntW      = 5;
  localparam int unsigned RootSteps = 24;
  localparam int unsigned CfgW      = 2;

  localparam logic signed [MulW-1:0]  GainQ16  = 25'sd19661;
  localparam logic signed [ProdW-1:0] RoundQ16 = 50'sd32768;
  localparam logic [SqW-1:0]          MinMagSq = 48'd65536;
  localparam logic [QuotW-1:0]        UnitMag  = 15'd16384;

  typedef enum logic [1:0] {
    REQ_TILT     = 2'd0,
    REQ_GRAV     = 2'd1,
    REQ_RECENTER = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_HORIZ_AXIS   = 2'd0,
    CFG_VERT_AXIS    = 2'd1,
    CFG_HORIZ_INVERT = 2'd2,
    CFG_VERT_INVERT  = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FACC,
    ST_SMUL,
    ST_SACC,
    ST_CHK,
    ST_ROOT,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
  } ate_in_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [UnitW-1:0] tilt_h;
    logic signed [UnitW-1:0] tilt_v;
    logic signed [UnitW-1:0] grav_h;
    logic signed [UnitW-1:0] grav_v;
    logic signed [UnitW-1:0] grav_n;
  } ate_out_t;

  // code three behaves as z
  function automatic axis_e axis_of(logic [1:0] code);
    axis_e a;
    unique case (code)
      2'd0:    a = AXIS_X;
      2'd1:    a = AXIS_Y;
      default: a = AXIS_Z;
    endcase
    return a;
  endfunction

  // lowest axis used by neither selection
  function automatic axis_e third_axis(axis_e h, axis_e v);
    axis_e n;
    if (h != AXIS_X && v != AXIS_X) begin
      n = AXIS_X;
    end else if (h != AXIS_Y && v != AXIS_Y) begin
      n = AXIS_Y;
    end else begin
      n = AXIS_Z;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/accel_tilt_estimator_core.sv
// Accelerometer tilt estimator: filter, normalise and tilt/gravity output
`timescale 1ns / 1ps
`default_nettype none

// Takes one accelerometer item at a time (tilt request, gravity request or
// recenter event) and returns one result per tilt or gravity request. The
// sample runs through a three-axis low-pass filter (gain 0.30, first sample
// seeds it), the filtered vector is squared and summed, a bit-serial square
// root gives its magnitude and a restoring divider turns each axis into a
// Q1.14 unit component. Tilt requests report the deviation from a captured
// neutral vector; gravity requests report the oriented unit vector. A recenter
// event or a request code three is taken in the idle state, which it keeps. A
// tilt or gravity item runs through filter, squares, root and divisions (the
// very first sample skips the filter multiply); root and division are skipped
// when the filtered magnitude is below one LSB. The square root (one result
// bit a cycle) and the three divisions (one quotient bit a cycle) all run on
// one
// shared 48-bit subtract/compare unit, plus up to six multiplies on one shared
// 25x25 multiplier with a registered product. The input is not ready while
// an item is at work; a finished result waits in the output register while
// the next item is taken, and only holds back completion of that next item.
// Configuration writes go in at once and are only meant while idle.
module accel_tilt_estimator_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [1:0]                    cfg_idx_i,
  input  wire [ate_pkg::CfgW-1:0]      cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire ate_pkg::ate_in_t        in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output ate_pkg::ate_out_t            out_data_o
);

  localparam int unsigned FW = ate_pkg::FiltW;
  localparam int unsigned UW = ate_pkg::UnitW;
  localparam logic signed [UW:0] UnitOneW = 17'sd16384;

  // --- registers -------------------------------------------------------
  ate_pkg::state_e state_q, state_d;
  logic [1:0]      idx_q, idx_d;
  logic [ate_pkg::CntW-1:0] cnt_q, cnt_d;

  logic [1:0] horiz_q, horiz_d, vert_q, vert_d;
  logic       hinv_q, hinv_d, vinv_q, vinv_d;

  logic signed [FW-1:0] filt_q [3];
  logic signed [FW-1:0] filt_d [3];
  logic signed [UW-1:0] neut_q [3];
  logic signed [UW-1:0] neut_d [3];
  logic seeded_q, seeded_d, held_q, held_d, pend_q, pend_d;
  logic valid_q, valid_d, tilt_q, tilt_d;
  logic out_valid_q, out_valid_d;

  // payload, no reset
  ate_pkg::ate_in_t  smp_q, smp_d;
  ate_pkg::ate_out_t out_q, out_d;
  logic signed [ate_pkg::ProdW-1:0] prod_q, prod_d;
  logic [ate_pkg::SqW-1:0]   s_q, s_d, rem_q, rem_d, root_q, root_d, dsh_q, dsh_d;
  logic [ate_pkg::RootW-1:0] m_q, m_d;
  logic [ate_pkg::QuotW-1:0] quo_q, quo_d;
  logic signed [UW-1:0] unit_q [3];
  logic signed [UW-1:0] unit_d [3];

  // --- shared datapath signals -----------------------------------------
  logic signed [FW-1:0]            f_sel;
  logic signed [ate_pkg::AccelW-1:0] a_sel;
  logic signed [ate_pkg::MulW-1:0] mul_a, mul_b, diff_f;
  logic signed [ate_pkg::ProdW-1:0] rnd;
  logic [ate_pkg::SqW-1:0] sub_a, sub_b, bitv;
  logic [ate_pkg::SqW:0]   diff;
  logic                    ge;
  logic [ate_pkg::QuotW-1:0] quo_nx, quo_cl;
  logic [FW-1:0]           mag;
  logic [ate_pkg::SqW-1:0] root_nx;

  // result assembly
  ate_pkg::axis_e ax_h, ax_v, ax_n;
  logic           cap;
  logic signed [UW-1:0] uh, uv, un, nh, nv;
  logic signed [UW:0]   dh, dv;
  ate_pkg::ate_out_t    res;

  function automatic logic signed [FW-1:0] pick_filt(logic [1:0] sel,
      logic signed [FW-1:0] f0, logic signed [FW-1:0] f1, logic signed [FW-1:0] f2);
    logic signed [FW-1:0] r;
    unique case (sel)
      2'd0:    r = f0;
      2'd1:    r = f1;
      default: r = f2;
    endcase
    return r;
  endfunction

  function automatic logic signed [UW-1:0] pick_unit(ate_pkg::axis_e sel,
      logic signed [UW-1:0] u0, logic signed [UW-1:0] u1, logic signed [UW-1:0] u2);
    logic signed [UW-1:0] r;
    unique case (sel)
      ate_pkg::AXIS_X: r = u0;
      ate_pkg::AXIS_Y: r = u1;
      default:         r = u2;
    endcase
    return r;
  endfunction

  function automatic logic signed [UW-1:0] clamp_unit(logic signed [UW:0] x);
    logic signed [UW-1:0] r;
    if (x > UnitOneW) begin
      r = UnitOneW[UW-1:0];
    end else if (x < -UnitOneW) begin
      r = -UnitOneW[UW-1:0];
    end else begin
      r = x[UW-1:0];
    end
    return r;
  endfunction

  // --- operand selection -----------------------------------------------
  always_comb begin
    f_sel = pick_filt(idx_q, filt_q[0], filt_q[1], filt_q[2]);
    unique case (idx_q)
      2'd0:    a_sel = smp_q.accel_x;
      2'd1:    a_sel = smp_q.accel_y;
      default: a_sel = smp_q.accel_z;
    endcase
    // d = a*256 - filt always fits 25 bits
    diff_f = $signed({a_sel[ate_pkg::AccelW-1], a_sel, 8'b0}) - $signed({f_sel[FW-1], f_sel});
    if (state_q == ate_pkg::ST_FMUL) begin
      mul_a = diff_f;
      mul_b = ate_pkg::GainQ16;
    end else begin
      mul_a = $signed({f_sel[FW-1], f_sel});
      mul_b = $signed({f_sel[FW-1], f_sel});
    end
    prod_d = mul_a * mul_b;
    rnd    = prod_q + ate_pkg::RoundQ16;

    // shared subtract/compare: root trial or shifted divisor
    bitv = ate_pkg::SqW'(1) << {cnt_q, 1'b0};
    sub_a = rem_q;
    if (state_q == ate_pkg::ST_ROOT) begin
      sub_b = root_q + bitv;
    end else begin
      sub_b = dsh_q;
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[ate_pkg::SqW];

    root_nx = ge ? ((root_q >> 1) + bitv) : (root_q >> 1);
    quo_nx  = {quo_q[ate_pkg::QuotW-2:0], ge};
    quo_cl  = (quo_nx > ate_pkg::UnitMag) ? ate_pkg::UnitMag : quo_nx;
    mag     = f_sel[FW-1] ? FW'(-f_sel) : FW'(f_sel);
  end

  // --- result assembly -------------------------------------------------
  always_comb begin
    ax_h = ate_pkg::axis_of(horiz_q);
    ax_v = ate_pkg::axis_of(vert_q);
    ax_n = ate_pkg::third_axis(ax_h, ax_v);
    uh   = pick_unit(ax_h, unit_q[0], unit_q[1], unit_q[2]);
    uv   = pick_unit(ax_v, unit_q[0], unit_q[1], unit_q[2]);
    un   = pick_unit(ax_n, unit_q[0], unit_q[1], unit_q[2]);
    // new neutral on first valid tilt or after a recenter
    cap  = tilt_q && valid_q && (pend_q || !held_q);
    nh   = cap ? uh : pick_unit(ax_h, neut_q[0], neut_q[1], neut_q[2]);
    nv   = cap ? uv : pick_unit(ax_v, neut_q[0], neut_q[1], neut_q[2]);
    dh   = $signed({uh[UW-1], uh}) - $signed({nh[UW-1], nh});
    dv   = $signed({uv[UW-1], uv}) - $signed({nv[UW-1], nv});
    if (hinv_q) begin
      dh = -dh;
    end
    if (vinv_q) begin
      dv = -dv;
    end
    res = '0;
    if (valid_q) begin
      res.valid_res = 1'b1;
      if (tilt_q) begin
        res.tilt_h = clamp_unit(dh);
        res.tilt_v = clamp_unit(dv);
      end else begin
        res.grav_h = hinv_q ? -uh : uh;
        res.grav_v = vinv_q ? -uv : uv;
        res.grav_n = un;
      end
    end
  end

  // --- sequencer -------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    horiz_d     = horiz_q;
    vert_d      = vert_q;
    hinv_d      = hinv_q;
    vinv_d      = vinv_q;
    filt_d      = filt_q;
    neut_d      = neut_q;
    seeded_d    = seeded_q;
    held_d      = held_q;
    pend_d      = pend_q;
    valid_d     = valid_q;
    tilt_d      = tilt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    smp_d       = smp_q;
    out_d       = out_q;
    s_d         = s_q;
    rem_d       = rem_q;
    root_d      = root_q;
    dsh_d       = dsh_q;
    m_d         = m_q;
    quo_d       = quo_q;
    unit_d      = unit_q;
    in_ready_o  = (state_q == ate_pkg::ST_IDLE);

    if (cfg_we_i) begin
      unique case (ate_pkg::cfg_e'(cfg_idx_i))
        ate_pkg::CFG_HORIZ_AXIS:   horiz_d = cfg_wdata_i[1:0];
        ate_pkg::CFG_VERT_AXIS:    vert_d  = cfg_wdata_i[1:0];
        ate_pkg::CFG_HORIZ_INVERT: hinv_d  = cfg_wdata_i[0];
        ate_pkg::CFG_VERT_INVERT:  vinv_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end

    unique case (state_q)
      ate_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (ate_pkg::req_e'(in_data_i.req_type))
            ate_pkg::REQ_RECENTER: pend_d = 1'b1;
            ate_pkg::REQ_TILT, ate_pkg::REQ_GRAV: begin
              smp_d  = in_data_i;
              tilt_d = (in_data_i.req_type == ate_pkg::REQ_TILT);
              idx_d  = 2'd0;
              s_d    = '0;
              if (seeded_q) begin
                state_d = ate_pkg::ST_FMUL;
              end else begin
                // first sample loads the filter directly
                filt_d[0] = {in_data_i.accel_x, 8'b0};
                filt_d[1] = {in_data_i.accel_y, 8'b0};
                filt_d[2] = {in_data_i.accel_z, 8'b0};
                seeded_d  = 1'b1;
                state_d   = ate_pkg::ST_SMUL;
              end
            end
            default: ;
          endcase
        end
      end
      ate_pkg::ST_FMUL: state_d = ate_pkg::ST_FACC;
      ate_pkg::ST_FACC: begin
        filt_d[idx_q] = f_sel + $signed(rnd[FW+15:16]);
        if (idx_q == 2'd2) begin
          idx_d   = 2'd0;
          state_d = ate_pkg::ST_SMUL;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ate_pkg::ST_FMUL;
        end
      end
      ate_pkg::ST_SMUL: state_d = ate_pkg::ST_SACC;
      ate_pkg::ST_SACC: begin
        s_d = s_q + prod_q[ate_pkg::SqW-1:0];
        if (idx_q == 2'd2) begin
          state_d = ate_pkg::ST_CHK;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ate_pkg::ST_SMUL;
        end
      end
      ate_pkg::ST_CHK: begin
        valid_d = (s_q >= ate_pkg::MinMagSq);
        rem_d   = s_q;
        root_d  = '0;
        cnt_d   = ate_pkg::CntW'(ate_pkg::RootSteps - 1);
        state_d = (s_q >= ate_pkg::MinMagSq) ? ate_pkg::ST_ROOT : ate_pkg::ST_DONE;
      end
      ate_pkg::ST_ROOT: begin
        if (ge) begin
          rem_d = diff[ate_pkg::SqW-1:0];
        end
        root_d = root_nx;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          m_d     = root_nx[ate_pkg::RootW-1:0];
          idx_d   = 2'd0;
          state_d = ate_pkg::ST_DLOAD;
        end
      end
      ate_pkg::ST_DLOAD: begin
        // q = (|f|*32768 + m) / (2m)
        rem_d   = ate_pkg::SqW'({mag, 15'b0}) + ate_pkg::SqW'(m_q);
        dsh_d   = ate_pkg::SqW'({m_q, 1'b0, 14'b0});
        quo_d   = '0;
        cnt_d   = ate_pkg::CntW'(ate_pkg::QuotW - 1);
        state_d = ate_pkg::ST_DIV;
      end
      ate_pkg::ST_DIV: begin
        if (ge) begin
          rem_d = diff[ate_pkg::SqW-1:0];
        end
        dsh_d = dsh_q >> 1;
        quo_d = quo_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          unit_d[idx_q] = f_sel[FW-1] ? -$signed({1'b0, quo_cl}) : $signed({1'b0, quo_cl});
          if (idx_q == 2'd2) begin
            state_d = ate_pkg::ST_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = ate_pkg::ST_DLOAD;
          end
        end
      end
      ate_pkg::ST_DONE: begin
        // wait while the previous result is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          out_d       = res;
          out_valid_d = 1'b1;
          if (cap) begin
            neut_d = unit_q;
            held_d = 1'b1;
            pend_d = 1'b0;
          end
          state_d = ate_pkg::ST_IDLE;
        end
      end
      default: state_d = ate_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ate_pkg::ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      horiz_q     <= 2'd0;
      vert_q      <= 2'd1;
      hinv_q      <= 1'b0;
      vinv_q      <= 1'b0;
      filt_q      <= '{default: '0};
      neut_q      <= '{default: '0};
      seeded_q    <= 1'b0;
      held_q      <= 1'b0;
      pend_q      <= 1'b0;
      valid_q     <= 1'b0;
      tilt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      horiz_q     <= horiz_d;
      vert_q      <= vert_d;
      hinv_q      <= hinv_d;
      vinv_q      <= vinv_d;
      filt_q      <= filt_d;
      neut_q      <= neut_d;
      seeded_q    <= seeded_d;
      held_q      <= held_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
      tilt_q      <= tilt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q  <= smp_d;
    out_q  <= out_d;
    prod_q <= prod_d;
    s_q    <= s_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    dsh_q  <= dsh_d;
    m_q    <= m_d;
    quo_q  <= quo_d;
    unit_q <= unit_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --- assertions ------------------------------------------------------
  logic root_div_busy, work_req;
  assign root_div_busy = (state_q == ate_pkg::ST_ROOT) || (state_q == ate_pkg::ST_DLOAD) ||
                         (state_q == ate_pkg::ST_DIV);
  assign work_req      = in_valid_i && in_ready_o && !in_data_i.req_type[1];

`include "accel_tilt_estimator_core_assert.svh"

  // root and division only ever run on a sample of usable magnitude
  `ATE_ASSERT_IMP(a_div_needs_valid, clk_i, rst_ni, root_div_busy, valid_q)
  // once captured, a neutral vector is never dropped
  `ATE_ASSERT_NXT(a_neutral_kept, clk_i, rst_ni, held_q, held_q)
  // a result only appears out of the completion step
  `ATE_ASSERT_IMP(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == ate_pkg::ST_DONE)
  // an accepted tilt or gravity request always starts work
  `ATE_ASSERT_NXT(a_request_starts, clk_i, rst_ni, work_req, state_q != ate_pkg::ST_IDLE)

endmodule

`default_nettype wire

>>> dv/tb_accel_tilt_estimator_core.sv
// Testbench for the tilt estimator core: directed table, then random samples, all checked
`timescale 1ns / 1ps

module tb_accel_tilt_estimator_core;
  import ate_pkg::*;

  typedef longint unsigned u64_t;

  localparam int PlanLen       = 20;
  localparam int Phases        = 15;
  localparam int PhaseItems    = 60;
  localparam int SettleCycles  = 100;   // covers the slowest item
  localparam int DrainCycles   = 200;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 4000;

  // fixed settings {horiz_axis, vert_axis, horiz_invert, vert_invert}; later phases are random
  localparam logic [5:0] FixedCfg [8] = '{
    6'b00_01_0_0,   // reset values
    6'b10_00_1_1,
    6'b01_10_0_1,
    6'b11_01_1_0,   // axis code three acts as z
    6'b00_00_0_0,   // equal axes
    6'b10_11_1_1,   // equal axes by way of code three
    6'b01_00_1_0,
    6'b11_11_0_1
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ate_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ate_out_t out_item;

  accel_tilt_estimator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioural estimate: filter, magnitude, unit vector, neutral and tilt
  // ---------------------------------------------------------------------------
  logic signed [FiltW-1:0] lp [3];      // filtered accel, Q.8
  bit                      lp_seeded;
  logic signed [UnitW-1:0] ntr [3];     // neutral unit vector, Q1.14
  bit                      ntr_held;
  bit                      recenter_armed;
  logic [1:0]              sel_h = 2'd0, sel_v = 2'd1;
  bit                      inv_h, inv_v;

  ate_out_t tilt_results_due [$];
  int       mismatches;

  function automatic logic signed [FiltW-1:0] lp_update(logic signed [FiltW-1:0] f,
                                                        logic signed [AccelW-1:0] a);
    longint d, t;
    d = longint'(a) * 256 - longint'(f);
    t = d * 19661 + 32768;
    return FiltW'(longint'(f) + (t >>> 16));   // arithmetic shift is a floor divide
  endfunction

  function automatic u64_t sq64(logic signed [FiltW-1:0] f);
    longint t;
    t = longint'(f);
    return u64_t'(t * t);
  endfunction

  function automatic u64_t root_floor(u64_t s);
    u64_t r, b;
    r = 0;
    b = u64_t'(1) << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // |f|*16384/m rounded half up, capped at one
  function automatic logic signed [UnitW-1:0] unit_of(logic signed [FiltW-1:0] f, u64_t m);
    longint fl;
    u64_t   mag, q;
    int     qi;
    fl  = longint'(f);
    mag = u64_t'(fl < 0 ? -fl : fl);
    q   = (mag * 32768 + m) / (2 * m);
    if (q > 16384) q = 16384;
    qi = int'(q);
    return (fl < 0) ? UnitW'(-qi) : UnitW'(qi);
  endfunction

  function automatic int axis_pick(logic [1:0] c);
    return (c > 2'd2) ? 2 : int'(c);
  endfunction

  function automatic logic signed [UnitW-1:0] clip_unit(int v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return UnitW'(v);
  endfunction

  function automatic logic signed [UnitW-1:0] flip(logic signed [UnitW-1:0] u, bit neg);
    return neg ? UnitW'(-int'(u)) : u;
  endfunction

  task automatic estimate_tilt(input ate_in_t it, output bit yields, output ate_out_t r);
    logic signed [AccelW-1:0] acc [3];
    logic signed [UnitW-1:0]  u [3];
    u64_t s, m;
    int h, v, n, dh, dv;
    r = '0;
    yields = 1'b0;
    acc[0] = it.accel_x;
    acc[1] = it.accel_y;
    acc[2] = it.accel_z;
    case (req_e'(it.req_type))
      REQ_RECENTER: begin
        recenter_armed = 1'b1;
        return;
      end
      REQ_NONE: return;
      default: ;
    endcase
    yields = 1'b1;
    for (int k = 0; k < 3; k++) begin
      lp[k] = lp_seeded ? lp_update(lp[k], acc[k]) : {acc[k], 8'h00};
    end
    lp_seeded = 1'b1;
    s = sq64(lp[0]) + sq64(lp[1]) + sq64(lp[2]);
    // below one LSB of magnitude the result is all zero; neutral and pending stay put
    if (s < u64_t'(65536)) return;
    m = root_floor(s);
    for (int k = 0; k < 3; k++) u[k] = unit_of(lp[k], m);
    h = axis_pick(sel_h);
    v = axis_pick(sel_v);
    r.valid_res = 1'b1;
    if (req_e'(it.req_type) == REQ_TILT) begin
      if (recenter_armed || !ntr_held) begin
        ntr = u;
        ntr_held = 1'b1;
        recenter_armed = 1'b0;
      end
      dh = int'(u[h]) - int'(ntr[h]);
      dv = int'(u[v]) - int'(ntr[v]);
      if (inv_h) dh = -dh;
      if (inv_v) dv = -dv;
      r.tilt_h = clip_unit(dh);
      r.tilt_v = clip_unit(dv);
    end else begin
      // gravity never touches the neutral vector or a pending recenter
      n = 0;
      while (n < 2 && (n == h || n == v)) n++;
      r.grav_h = flip(u[h], inv_h);
      r.grav_v = flip(u[v], inv_v);
      r.grav_n = u[n];
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output check, sampled at the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic signed [UnitW-1:0] want,
                             logic signed [UnitW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ate_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tilt_results_due.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, got %p", $time, out_item);
        mismatches++;
      end else begin
        want = tilt_results_due.pop_front();
        check_field("valid_res", {15'd0, want.valid_res}, {15'd0, out_item.valid_res});
        check_field("tilt_h", want.tilt_h, out_item.tilt_h);
        check_field("tilt_v", want.tilt_v, out_item.tilt_v);
        check_field("grav_h", want.grav_h, out_item.grav_h);
        check_field("grav_v", want.grav_v, out_item.grav_v);
        check_field("grav_n", want.grav_n, out_item.grav_n);
      end
    end
  end

  // watchdog: cycles in which no item moves on either side
  int stall_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts, one long hold on request, none in the tail
  // ---------------------------------------------------------------------------
  bit hold_rx;
  bit rx_idle = 1'b1;
  bit tail;

  initial begin
    bit lvl;
    int len;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        lvl = 1'b0;
        len = LongHold;
        hold_rx = 1'b0;
      end else if (!rx_idle || tail) begin
        lvl = 1'b1;
        len = 1;
      end else begin
        lvl = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 19);
      end
      @(negedge clk);
      out_ready <= lvl;
      repeat (len - 1) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // valid goes up at a falling edge and stays up until a rising edge sees ready
  task automatic offer_item(input ate_in_t it, input bit typed, input ate_out_t want);
    bit       yields;
    ate_out_t r;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    estimate_tilt(it, yields, r);
    if (yields) tilt_results_due.push_back(typed ? want : r);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop offering, wait for every result, then let a recenter or dropped item finish
  task automatic drain;
    idle_gap(1);
    while (tilt_results_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e idx, logic [1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HORIZ_AXIS:   sel_h = val;
      CFG_VERT_AXIS:    sel_v = val;
      CFG_HORIZ_INVERT: inv_h = val[0];
      CFG_VERT_INVERT:  inv_v = val[0];
      default: ;
    endcase
  endtask

  function automatic ate_in_t mk(req_e r, int x, int y, int z);
    ate_in_t it;
    it.req_type = r;
    it.accel_x  = AccelW'(x);
    it.accel_y  = AccelW'(y);
    it.accel_z  = AccelW'(z);
    return it;
  endfunction

  function automatic logic signed [AccelW-1:0] sat16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return AccelW'(v);
  endfunction

  function automatic logic signed [AccelW-1:0] extreme16();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // random items: mostly a held orientation with sensor noise, plus noise items,
  // extremes and quiet runs that let the filter decay below one LSB
  int base [3];
  int quiet_left;

  task automatic draw_item(output ate_in_t it);
    logic signed [AccelW-1:0] comp [3];
    int pick;
    if ($urandom_range(0, 24) == 0) begin
      for (int k = 0; k < 3; k++) begin
        base[k] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 6)) - 3
                                               : int'($urandom_range(0, 40000)) - 20000;
      end
    end
    if (quiet_left == 0 && $urandom_range(0, 299) == 0) quiet_left = 45;
    pick = $urandom_range(0, 99);
    it.req_type = ($urandom_range(0, 9) < 7) ? REQ_TILT : REQ_GRAV;
    for (int k = 0; k < 3; k++) comp[k] = AccelW'($urandom());
    if (quiet_left > 0) begin
      quiet_left--;
      for (int k = 0; k < 3; k++) comp[k] = AccelW'(int'($urandom_range(0, 2)) - 1);
    end else if (pick < 3) begin
      it.req_type = REQ_NONE;
    end else if (pick < 8) begin
      it.req_type = REQ_RECENTER;
    end else if (pick < 20) begin
      // fully random sample, already drawn
    end else if (pick < 28) begin
      for (int k = 0; k < 3; k++) comp[k] = extreme16();
    end else begin
      for (int k = 0; k < 3; k++) comp[k] = sat16(base[k] + int'($urandom_range(0, 400)) - 200);
    end
    it.accel_x = comp[0];
    it.accel_y = comp[1];
    it.accel_z = comp[2];
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  ate_in_t  plan_item  [PlanLen];
  bit       plan_typed [PlanLen];
  ate_out_t plan_want  [PlanLen];

  initial begin
    ate_in_t    it;
    bit         tx_idle;
    int         done;
    logic [5:0] cfg;

    // directed table, run with the reset configuration (x horizontal, y vertical)
    plan_item[0]  = mk(REQ_TILT, 0, 0, 0);            // seeds the filter at zero
    plan_item[1]  = mk(REQ_GRAV, 0, 0, 0);            // stays at zero
    plan_item[2]  = mk(REQ_TILT, 1, -1, 1);           // still below one LSB
    plan_item[3]  = mk(REQ_RECENTER, 32767, -32768, 32767);
    plan_item[4]  = mk(REQ_NONE, -32768, 32767, -1);  // dropped
    plan_item[5]  = mk(REQ_GRAV, 32767, 32767, 32767); // must not take the recenter
    plan_item[6]  = mk(REQ_TILT, -32768, -32768, -32768); // first neutral capture
    plan_item[7]  = mk(REQ_TILT, 32767, 0, 0);
    plan_item[8]  = mk(REQ_TILT, 0, 32767, 0);
    plan_item[9]  = mk(REQ_GRAV, 0, 0, -32768);
    plan_item[10] = mk(REQ_RECENTER, 0, 0, 0);
    plan_item[11] = mk(REQ_GRAV, 0, -32768, 0);
    plan_item[12] = mk(REQ_TILT, 0, -32768, 0);        // recapture
    plan_item[13] = mk(REQ_TILT, 32767, -32768, 32767);
    plan_item[14] = mk(REQ_TILT, -32768, 32767, -32768);
    plan_item[15] = mk(REQ_GRAV, -32768, -32768, 32767);
    plan_item[16] = mk(REQ_NONE, -1, -1, -1);
    plan_item[17] = mk(REQ_TILT, 21845, -21846, 12345);
    plan_item[18] = mk(REQ_GRAV, 100, -200, 300);
    plan_item[19] = mk(REQ_TILT, -1, -1, -1);
    for (int i = 0; i < PlanLen; i++) begin
      plan_typed[i] = 1'b0;
      plan_want[i]  = '0;
    end
    // zero vector straight after reset: invalid, every field zero
    plan_typed[0] = 1'b1;
    plan_typed[1] = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PlanLen; i++) begin
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 19));
      offer_item(plan_item[i], plan_typed[i], plan_want[i]);
    end

    // random phases, each under its own configuration
    for (int p = 0; p < Phases; p++) begin
      drain();
      if (p < 8) begin
        cfg = FixedCfg[p];
      end else begin
        cfg = {2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
      end
      // the spare top bit of the invert writes is random and must be ignored
      write_reg(CFG_HORIZ_AXIS, cfg[5:4]);
      write_reg(CFG_VERT_AXIS, cfg[3:2]);
      write_reg(CFG_HORIZ_INVERT, {1'($urandom_range(0, 1)), cfg[1]});
      write_reg(CFG_VERT_INVERT, {1'($urandom_range(0, 1)), cfg[0]});
      @(negedge clk);
      cfg_we <= 1'b0;

      tail    = (p == Phases - 1);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      done    = 0;
      while (done < PhaseItems) begin
        draw_item(it);
        // in phase two the receiver holds off while items keep coming
        if (p == 2 && done == 10) hold_rx = 1'b1;
        if (tx_idle && !tail && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 19));
        offer_item(it, 1'b0, '0);
        if (req_e'(it.req_type) != REQ_NONE) done++;
      end
    end

    idle_gap(1);
    while (tilt_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tilt_results_due.size() != 0) begin
      $display("%0t: results never arrived: expected %0d more, got 0",
               $time, tilt_results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> accel_tilt_estimator_core.f
+incdir+hdl
hdl/ate_pkg.sv
hdl/accel_tilt_estimator_core.sv
dv/tb_accel_tilt_estimator_core.sv
